// ===== rtl/stg_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stg_pkg
// shared types, opcodes and constants of the stepper step generator
// ---------------------------------------------------------------------------
package stg_pkg;

    localparam int DELAY_BITS     = 20;
    localparam int POS_BITS       = 32;
    localparam int STEP_BITS      = 31;
    localparam int CNT_BITS       = 32;
    localparam int MIN_RAMP_STEPS = 10;
    localparam int HOME_TARGET    = 999999;

    // x / 5 == (x * DIV5_RECIP) >> DIV5_SHIFT for any 32-bit x
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_HOME = 2'd2,
        OP_ZERO = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DONE  = 2'd1,
        EV_LIM_A = 2'd2,
        EV_LIM_B = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_HOLD   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        REG_ACCEL  = 2'd0,
        REG_DECEL  = 2'd1,
        REG_START  = 2'd2,
        REG_ENABLE = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PLAN,
        S_DIV,
        S_FIN,
        S_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch input request
        logic exec;      // run command or tick
        logic plan;      // clamp ramps against the 2/5 limit
        logic div_start; // start serial divider
        logic finish;    // apply divider result
        logic out_load;  // load result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_plan;
        logic need_div;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/stg_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stg_div
// radix-2 restoring divider, unsigned, one quotient bit per cycle
// ---------------------------------------------------------------------------
module stg_div
    import stg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          dividend,
    input  logic [CNT_BITS-1:0]  divisor,
    output logic [63:0]          quotient,
    output logic                 done
);

    logic [63:0]         quo_reg, quo_next;
    logic [CNT_BITS:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0] dvs_reg, dvs_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CNT_BITS-1:0], quo_reg[63]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/stg_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stg_datapath
// motion state, ramp planning, delay interpolation and result register
// ---------------------------------------------------------------------------
module stg_datapath
    import stg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [1:0]            opcode,
    input  logic [STEP_BITS-1:0]  step_count,
    input  logic                  move_dir,
    input  logic [DELAY_BITS-1:0] speed_delay,
    input  logic                  limit_a_hit,
    input  logic                  limit_b_hit,
    input  logic                  home_hit,
    input  logic [15:0]           accel_amount,
    input  logic [15:0]           decel_amount,
    input  logic [DELAY_BITS-1:0] start_delay,
    input  logic                  enable_used,
    output logic                  step_pulse,
    output logic                  dir_level,
    output logic                  enable_on,
    output logic signed [31:0]    cur_position,
    output logic                  is_moving,
    output logic [1:0]            event_code
);

    // captured request
    logic [1:0]            op_reg;
    logic [STEP_BITS-1:0]  steps_reg;
    logic                  mdir_reg, lima_reg, limb_reg, home_reg;
    logic [DELAY_BITS-1:0] speed_reg;

    // motion state
    logic                  running_reg, running_next;
    logic                  homing_reg, homing_next;
    logic                  dir_reg, dir_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   tgt_reg, tgt_next;
    logic [DELAY_BITS-1:0] run_dly_reg, run_dly_next;
    logic [DELAY_BITS-1:0] cur_dly_reg, cur_dly_next;
    logic [DELAY_BITS-1:0] elap_reg, elap_next;
    logic [CNT_BITS-1:0]   done_reg, done_next;
    logic [CNT_BITS-1:0]   total_reg, total_next;
    logic [CNT_BITS-1:0]   alen_reg, alen_next;
    logic [CNT_BITS-1:0]   dlen_reg, dlen_next;
    logic [1:0]            phase_reg, phase_next;

    // per-item scratch
    logic                  pulse_reg, pulse_next;
    logic [1:0]            ev_reg, ev_next;
    logic                  need_div_reg, need_div_next;
    logic                  need_plan_reg, need_plan_next;
    logic                  neg_reg, neg_next;
    logic [63:0]           dvd_reg, dvd_next;
    logic [CNT_BITS-1:0]   dvs_reg, dvs_next;
    logic [DELAY_BITS-1:0] from_reg, from_next;
    logic [CNT_BITS-1:0]   lim_reg, lim_next;

    // result
    logic                  o_pulse_reg, o_dir_reg, o_en_reg, o_mov_reg;
    logic [POS_BITS-1:0]   o_pos_reg;
    logic [1:0]            o_ev_reg;

    logic [63:0] quo;
    logic        div_done;
    logic        ramp_on;

    assign ramp_on = (accel_amount != 16'd0) || (decel_amount != 16'd0);

    stg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quo),
        .done     (div_done)
    );

    assign stat.need_plan = need_plan_reg;
    assign stat.need_div  = need_div_reg;
    assign stat.div_done  = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            homing_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            pos_reg     <= '0;
            tgt_reg     <= '0;
            run_dly_reg <= '0;
            cur_dly_reg <= DELAY_BITS'(1000);
            elap_reg    <= '0;
            done_reg    <= '0;
            total_reg   <= '0;
            alen_reg    <= '0;
            dlen_reg    <= '0;
            phase_reg   <= PH_ACCEL;
        end
        else
        begin
            running_reg <= running_next;
            homing_reg  <= homing_next;
            dir_reg     <= dir_next;
            pos_reg     <= pos_next;
            tgt_reg     <= tgt_next;
            run_dly_reg <= run_dly_next;
            cur_dly_reg <= cur_dly_next;
            elap_reg    <= elap_next;
            done_reg    <= done_next;
            total_reg   <= total_next;
            alen_reg    <= alen_next;
            dlen_reg    <= dlen_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            steps_reg <= step_count;
            mdir_reg  <= move_dir;
            speed_reg <= speed_delay;
            lima_reg  <= limit_a_hit;
            limb_reg  <= limit_b_hit;
            home_reg  <= home_hit;
        end
        pulse_reg     <= pulse_next;
        ev_reg        <= ev_next;
        need_div_reg  <= need_div_next;
        need_plan_reg <= need_plan_next;
        neg_reg       <= neg_next;
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        from_reg      <= from_next;
        lim_reg       <= lim_next;
        if (cmd.out_load)
        begin
            o_pulse_reg <= pulse_reg;
            o_dir_reg   <= dir_reg;
            o_en_reg    <= running_reg & enable_used;
            o_pos_reg   <= pos_reg;
            o_mov_reg   <= running_reg;
            o_ev_reg    <= ev_reg;
        end
    end

    // ramp length: amount capped at the 2/5 limit, floor of MIN_RAMP_STEPS, used in planning
    function automatic logic [CNT_BITS-1:0] ramp_len(input logic [15:0] amt,
                                                     input logic [CNT_BITS-1:0] lim);
        logic [CNT_BITS-1:0] v;
        begin
            v = ({16'd0, amt} < lim) ? {16'd0, amt} : lim;
            if (amt == 16'd0)
                ramp_len = '0;
            else
                ramp_len = (v > CNT_BITS'(MIN_RAMP_STEPS)) ? v : CNT_BITS'(MIN_RAMP_STEPS);
        end
    endfunction

    logic [CNT_BITS-1:0] sd1, a_l, d_l, half;
    logic [CNT_BITS:0] dstep, num;
    logic [POS_BITS-1:0] pos_step;
    logic [DELAY_BITS-1:0] dly;
    logic [DELAY_BITS:0] elap_inc;
    logic signed [DELAY_BITS+1:0] diff;
    logic [DELAY_BITS:0] mag;
    logic [DELAY_BITS+CNT_BITS+1:0] prod;
    logic [63:0] prod5;
    logic signed [65:0] sum;
    logic [CNT_BITS:0] ad_sum;

    always_comb
    begin
        running_next   = running_reg;
        homing_next    = homing_reg;
        dir_next       = dir_reg;
        pos_next       = pos_reg;
        tgt_next       = tgt_reg;
        run_dly_next   = run_dly_reg;
        cur_dly_next   = cur_dly_reg;
        elap_next      = elap_reg;
        done_next      = done_reg;
        total_next     = total_reg;
        alen_next      = alen_reg;
        dlen_next      = dlen_reg;
        phase_next     = phase_reg;
        pulse_next     = pulse_reg;
        ev_next        = ev_reg;
        need_div_next  = need_div_reg;
        need_plan_next = need_plan_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        from_next      = from_reg;
        lim_next       = lim_reg;
        sd1      = done_reg + 1'b1;
        dstep    = {1'b0, sd1} - ({1'b0, total_reg} - {1'b0, dlen_reg});
        num      = '0;
        a_l      = '0;
        d_l      = '0;
        half     = '0;
        pos_step = dir_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
        dly      = ramp_on ? cur_dly_reg : run_dly_reg;
        elap_inc = {1'b0, elap_reg} + 1'b1;
        diff     = '0;
        mag      = '0;
        prod     = '0;
        prod5    = '0;
        sum      = '0;
        ad_sum   = '0;

        if (cmd.capture)
        begin
            pulse_next     = 1'b0;
            ev_next        = EV_NONE;
            need_div_next  = 1'b0;
            need_plan_next = 1'b0;
        end

        if (cmd.exec)
        begin
            case (opcode_t'(op_reg))
                OP_MOVE:
                begin
                    tgt_next     = mdir_reg ? pos_reg + POS_BITS'(steps_reg)
                                            : pos_reg - POS_BITS'(steps_reg);
                    run_dly_next = speed_reg;
                    dir_next     = mdir_reg;
                    homing_next  = 1'b0;
                    elap_next    = '0;
                    cur_dly_next = speed_reg;
                    if (ramp_on)
                    begin
                        total_next = CNT_BITS'(steps_reg);
                        done_next  = '0;
                        // 2*total/5 by reciprocal multiplication
                        prod5          = 64'({steps_reg, 1'b0}) * 64'(DIV5_RECIP);
                        lim_next       = CNT_BITS'(prod5 >> DIV5_SHIFT);
                        need_plan_next = 1'b1;
                    end
                    if (tgt_next == pos_reg)
                    begin
                        running_next = 1'b0;
                        ev_next      = EV_DONE;
                    end
                    else
                        running_next = 1'b1;
                end
                OP_HOME:
                begin
                    dir_next     = 1'b0;
                    tgt_next     = POS_BITS'(0) - POS_BITS'(HOME_TARGET);
                    running_next = 1'b1;
                    homing_next  = 1'b1;
                    run_dly_next = speed_reg;
                    cur_dly_next = speed_reg;
                    elap_next    = '0;
                end
                OP_ZERO:
                begin
                    pos_next     = '0;
                    running_next = 1'b0;
                    homing_next  = 1'b0;
                end
                default:
                begin
                    if (running_reg)
                    begin
                        if (!homing_reg && dir_reg && lima_reg)
                        begin
                            running_next = 1'b0;
                            ev_next      = EV_LIM_A;
                        end
                        else if (!homing_reg && !dir_reg && limb_reg)
                        begin
                            running_next = 1'b0;
                            ev_next      = EV_LIM_B;
                        end
                        else
                        begin
                            if (elap_reg != DELAY_MAX)
                                elap_next = elap_inc[DELAY_BITS-1:0];
                            if (elap_next >= dly)
                            begin
                                pulse_next = 1'b1;
                                pos_next   = pos_step;
                                elap_next  = '0;
                                if (homing_reg && home_reg)
                                begin
                                    running_next = 1'b0;
                                    homing_next  = 1'b0;
                                    pos_next     = '0;
                                    ev_next      = EV_DONE;
                                end
                                else
                                begin
                                    if (ramp_on && !homing_reg)
                                    begin
                                        done_next = sd1;
                                        case (phase_t'(phase_reg))
                                            PH_ACCEL:
                                            begin
                                                if (sd1 < alen_reg)
                                                begin
                                                    diff = $signed({2'b0, run_dly_reg})
                                                         - $signed({2'b0, start_delay});
                                                    neg_next  = diff[DELAY_BITS+1];
                                                    mag = diff[DELAY_BITS+1]
                                                        ? (DELAY_BITS+1)'(-diff)
                                                        : (DELAY_BITS+1)'(diff);
                                                    num  = {1'b0, sd1};
                                                    prod = (DELAY_BITS+CNT_BITS+2)'(mag)
                                                         * (DELAY_BITS+CNT_BITS+2)'(num);
                                                    dvd_next  = 64'(prod);
                                                    dvs_next  = alen_reg;
                                                    from_next = start_delay;
                                                    need_div_next = 1'b1;
                                                end
                                                else
                                                begin
                                                    phase_next   = PH_CRUISE;
                                                    cur_dly_next = run_dly_reg;
                                                end
                                            end
                                            PH_CRUISE:
                                            begin
                                                if ($signed({1'b0, total_reg})
                                                    - $signed({1'b0, sd1})
                                                    <= $signed({1'b0, dlen_reg}))
                                                    phase_next = PH_DECEL;
                                            end
                                            PH_DECEL:
                                            begin
                                                if (dlen_reg == '0)
                                                    cur_dly_next = run_dly_reg;
                                                else
                                                begin
                                                    diff = $signed({2'b0, start_delay})
                                                         - $signed({2'b0, run_dly_reg});
                                                    // sign of product: diff * dstep
                                                    neg_next = diff[DELAY_BITS+1]
                                                             ^ dstep[CNT_BITS];
                                                    if (diff == '0) neg_next = 1'b0;
                                                    mag = diff[DELAY_BITS+1]
                                                        ? (DELAY_BITS+1)'(-diff)
                                                        : (DELAY_BITS+1)'(diff);
                                                    num = dstep[CNT_BITS] ? -dstep : dstep;
                                                    prod = (DELAY_BITS+CNT_BITS+2)'(mag)
                                                         * (DELAY_BITS+CNT_BITS+2)'(num);
                                                    dvd_next  = 64'(prod);
                                                    dvs_next  = dlen_reg;
                                                    from_next = run_dly_reg;
                                                    need_div_next = 1'b1;
                                                end
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                    end
                                    if (!homing_reg && pos_step == tgt_reg)
                                    begin
                                        running_next = 1'b0;
                                        ev_next      = EV_DONE;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
        end

        if (cmd.plan)
        begin
            a_l = ramp_len(accel_amount, lim_reg);
            d_l = ramp_len(decel_amount, lim_reg);
            ad_sum = {1'b0, a_l} + {1'b0, d_l};
            if (ad_sum > {1'b0, total_reg})
            begin
                half = total_reg >> 1;
                a_l  = half;
                d_l  = total_reg - half;
            end
            alen_next = a_l;
            dlen_next = d_l;
            if (a_l != '0)
            begin
                phase_next   = PH_ACCEL;
                cur_dly_next = start_delay;
            end
            else
            begin
                phase_next   = PH_CRUISE;
                cur_dly_next = run_dly_reg;
            end
            need_plan_next = 1'b0;
        end

        if (cmd.finish)
        begin
            sum = neg_reg ? $signed({2'b0, from_reg}) - $signed({2'b0, quo})
                          : $signed({2'b0, from_reg}) + $signed({2'b0, quo});
            if (sum < 0)
                cur_dly_next = '0;
            else if (sum > $signed({46'd0, DELAY_MAX}))
                cur_dly_next = DELAY_MAX;
            else
                cur_dly_next = sum[DELAY_BITS-1:0];
            need_div_next = 1'b0;
        end
    end

    assign step_pulse   = o_pulse_reg;
    assign dir_level    = o_dir_reg;
    assign enable_on    = o_en_reg;
    assign cur_position = $signed(o_pos_reg);
    assign is_moving    = o_mov_reg;
    assign event_code   = o_ev_reg;

    a_enable_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        o_en_reg |-> o_mov_reg)
        else $error("enable without motion");
    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (o_ev_reg != EV_NONE) |-> !o_mov_reg)
        else $error("event while still moving");
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !cmd.div_start)
        else $error("divider restarted");

endmodule

// ===== rtl/stg_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stg_ctrl
// sequencer: accept, execute, plan or divide, finish, present result
// ---------------------------------------------------------------------------
module stg_ctrl
    import stg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_PLAN;
            end
            S_PLAN:
            begin
                // ramp planning stays in this state, then the result is loaded
                if (stat.need_plan)
                    cmd.plan = 1'b1;
                else if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = stat.need_div;
                state_next = S_PLAN;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.exec)
        else $error("capture not followed by execute");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped under stall");

endmodule

// ===== rtl/stepper_trapezoid_step_generator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_trapezoid_step_generator
// one stepper channel with trapezoidal speed ramps
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries move, home, zero or tick requests;
// each request yields exactly one result on the output channel
// (out_valid/out_stall). Requests are handled one at a time: a request is
// taken, executed, then the result is registered and held. A move with
// ramping on also plans the ramps before the result is registered. A stepping
// tick that interpolates the ramp delay also runs the 64-step serial divider
// once, the worst case.
// While the receiver stalls, the result stays on the ports and in_stall is
// high, so no new request is taken.
// Reset (rst_n low) stops motion, zeroes position, restores start_delay to
// 5000 and the current delay to 1000, and clears the other configuration and
// motion registers; the captured request, scratch and result registers are
// not reset.
// Configuration must be written through the APB port only while no request
// is in flight; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module stepper_trapezoid_step_generator
    import stg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [STEP_BITS-1:0]  step_count,
    input  logic                  move_dir,
    input  logic [DELAY_BITS-1:0] speed_delay,
    input  logic                  limit_a_hit,
    input  logic                  limit_b_hit,
    input  logic                  home_hit,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  step_pulse,
    output logic                  dir_level,
    output logic                  enable_on,
    output logic signed [31:0]    cur_position,
    output logic                  is_moving,
    output logic [1:0]            event_code
);

    logic [15:0]           accel_reg, decel_reg;
    logic [DELAY_BITS-1:0] start_reg;
    logic                  en_used_reg;
    logic                  wr;
    dp_cmd_t               cmd;
    dp_stat_t              stat;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg   <= '0;
            decel_reg   <= '0;
            start_reg   <= DELAY_BITS'(5000);
            en_used_reg <= 1'b0;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_ACCEL:  accel_reg   <= pwdata[15:0];
                REG_DECEL:  decel_reg   <= pwdata[15:0];
                REG_START:  start_reg   <= pwdata[DELAY_BITS-1:0];
                REG_ENABLE: en_used_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx_t'(paddr[3:2]))
            REG_ACCEL:  prdata = {16'd0, accel_reg};
            REG_DECEL:  prdata = {16'd0, decel_reg};
            REG_START:  prdata = {12'd0, start_reg};
            REG_ENABLE: prdata = {31'd0, en_used_reg};
            default:    prdata = '0;
        endcase
    end

    stg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    stg_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .step_count   (step_count),
        .move_dir     (move_dir),
        .speed_delay  (speed_delay),
        .limit_a_hit  (limit_a_hit),
        .limit_b_hit  (limit_b_hit),
        .home_hit     (home_hit),
        .accel_amount (accel_reg),
        .decel_amount (decel_reg),
        .start_delay  (start_reg),
        .enable_used  (en_used_reg),
        .step_pulse   (step_pulse),
        .dir_level    (dir_level),
        .enable_on    (enable_on),
        .cur_position (cur_position),
        .is_moving    (is_moving),
        .event_code   (event_code)
    );

endmodule
